/* rtl/core/ecpc_pkg.sv */
// Shared types and constants of the escape count palette colorizer.
`default_nettype none

package ecpc_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_CLEAR_MAX = 2'd0;
  localparam logic [1:0] OP_SCAN      = 2'd1;
  localparam logic [1:0] OP_MAP       = 2'd2;
  localparam logic [1:0] OP_WRITE_PAL = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_SET_COLOR  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SET_EN     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_EXT_EN     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RELATIVE   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PAL_SIZE   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_GRAD_OFS   = 3'd5;
  localparam int unsigned CFG_DW = 32;

  // Color source codes.
  localparam logic [1:0] SRC_SET     = 2'd0;
  localparam logic [1:0] SRC_WHITE   = 2'd1;
  localparam logic [1:0] SRC_PALETTE = 2'd2;

  localparam logic [31:0] WHITE_RGBA    = 32'hFFFF_FFFF;
  localparam logic [31:0] SET_COLOR_RST = 32'h0000_00FF;
  localparam int unsigned SIZE_W        = 10;
  localparam logic [SIZE_W-1:0] PAL_SIZE_RST = 10'd300;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted word
    logic clr_max;    // clear the frame maximum
    logic scan;       // fold the count into the frame maximum
    logic wr_pal;     // write one palette entry
    logic mul;        // register count * size
    logic div_start;  // start the shared divider
    logic div_mod;    // 1: modulo pass, 0: scaling pass
    logic ram_rd;     // read the palette at the remainder
    logic out_load;   // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pal_path;   // the latched pixel takes its color from the palette
    logic relative;   // relative mode is on
    logic div_busy;   // the divider is still iterating
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ecpc_ram.sv */
// Generic single write port RAM with registered read.
`default_nettype none

module ecpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ecpc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module ecpc_div #(
  parameter int unsigned DW = 35,
  parameter int unsigned VW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DW-1:0]      quotient_o,
  output logic [VW-1:0]      remainder_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          fits;

  // The partial remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign busy_o      = cnt_q != '0;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* rtl/core/ecpc_dp.sv */
// Datapath: configuration, frame maximum, palette, index arithmetic and output register.
`default_nettype none

module ecpc_dp #(
  parameter int unsigned PALETTE_DEPTH = 512,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ecpc_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire logic [ecpc_pkg::CFG_DW-1:0]   cfg_data_i,
  input  wire logic                          in_set_i,
  input  wire logic                          has_count_i,
  input  wire logic [COUNT_BITS-1:0]         escape_count_i,
  input  wire logic [8:0]                    entry_index_i,
  input  wire logic [31:0]                   entry_color_i,
  input  wire ecpc_pkg::ctrl_cmd_t           cmd_i,
  output ecpc_pkg::ctrl_stat_t               stat_o,
  output logic [31:0]                        pixel_rgba_o,
  output logic [1:0]                         color_source_o
);

  localparam int unsigned SW = ecpc_pkg::SIZE_W;
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned DW = COUNT_BITS + SW + 1;
  localparam int unsigned VW = (COUNT_BITS > SW) ? COUNT_BITS : SW;

  // Configuration registers.
  logic [31:0]   set_color_q;
  logic          set_en_q;
  logic          ext_en_q;
  logic          relative_q;
  logic [SW-1:0] pal_size_q;
  logic [SW-1:0] grad_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_color_q <= ecpc_pkg::SET_COLOR_RST;
      set_en_q    <= 1'b1;
      ext_en_q    <= 1'b1;
      relative_q  <= 1'b0;
      pal_size_q  <= ecpc_pkg::PAL_SIZE_RST;
      grad_ofs_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ecpc_pkg::CFG_SET_COLOR: set_color_q <= cfg_data_i[31:0];
        ecpc_pkg::CFG_SET_EN:    set_en_q    <= cfg_data_i[0];
        ecpc_pkg::CFG_EXT_EN:    ext_en_q    <= cfg_data_i[0];
        ecpc_pkg::CFG_RELATIVE:  relative_q  <= cfg_data_i[0];
        ecpc_pkg::CFG_PAL_SIZE:  pal_size_q  <= cfg_data_i[SW-1:0];
        ecpc_pkg::CFG_GRAD_OFS:  grad_ofs_q  <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Size in use: zero reads as one, anything above the palette depth saturates.
  logic [SW-1:0] size_eff;
  always_comb begin
    if (pal_size_q == '0) begin
      size_eff = SW'(1);
    end else if (32'(pal_size_q) > 32'(PALETTE_DEPTH)) begin
      size_eff = SW'(PALETTE_DEPTH);
    end else begin
      size_eff = pal_size_q;
    end
  end

  // Frame maximum of valid counts.
  logic [COUNT_BITS-1:0] max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cmd_i.clr_max) begin
      max_q <= '0;
    end else if (cmd_i.scan && has_count_i && (escape_count_i > max_q)) begin
      max_q <= escape_count_i;
    end
  end

  // Latched pixel of a map word.
  logic                  in_set_q;
  logic                  has_count_q;
  logic [COUNT_BITS-1:0] count_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_set_q    <= in_set_i;
      has_count_q <= has_count_i;
      count_q     <= escape_count_i;
    end
  end

  logic [1:0] src;
  always_comb begin
    if (in_set_q && set_en_q) begin
      src = ecpc_pkg::SRC_SET;
    end else if (!ext_en_q || !has_count_q) begin
      src = ecpc_pkg::SRC_WHITE;
    end else begin
      src = ecpc_pkg::SRC_PALETTE;
    end
  end

  // Scaling product for relative mode.
  logic [DW-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= DW'(count_q) * DW'(size_eff);
    end
  end

  // Shared divider: in relative mode first count*size / max, then in both modes (base + offset) mod size.
  logic [DW-1:0] quotient;
  logic [VW-1:0] remainder;
  logic          div_busy;
  logic [DW-1:0] mod_base;
  logic [DW-1:0] dividend;
  logic [VW-1:0] divisor;
  logic [VW-1:0] max_eff;

  assign max_eff  = (max_q == '0) ? VW'(1) : VW'(max_q);
  assign mod_base = (relative_q ? quotient : DW'(count_q)) + DW'(grad_ofs_q);
  assign dividend = cmd_i.div_mod ? mod_base : prod_q;
  assign divisor  = cmd_i.div_mod ? VW'(size_eff) : max_eff;

  ecpc_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .busy_o      (div_busy),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  // Palette memory. Writes at or above the depth are dropped.
  logic          wr_ok;
  logic [31:0]   pal_rdata;
  assign wr_ok = cmd_i.wr_pal && (32'(entry_index_i) < 32'(PALETTE_DEPTH));

  ecpc_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (entry_color_i),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (AW'(remainder)),
    .rdata_o (pal_rdata)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_source_o <= src;
      unique case (src)
        ecpc_pkg::SRC_SET:   pixel_rgba_o <= set_color_q;
        ecpc_pkg::SRC_WHITE: pixel_rgba_o <= ecpc_pkg::WHITE_RGBA;
        default:             pixel_rgba_o <= pal_rdata;
      endcase
    end
  end

  assign stat_o.pal_path = src == ecpc_pkg::SRC_PALETTE;
  assign stat_o.relative = relative_q;
  assign stat_o.div_busy = div_busy;

endmodule

`default_nettype wire

/* rtl/core/ecpc_ctrl.sv */
// Controller state machine: input and output handshakes and sequencing of a map.
`default_nettype none

module ecpc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           opcode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire ecpc_pkg::ctrl_stat_t stat_i,
  output ecpc_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MOD_GO,
    S_MOD_WAIT,
    S_READ,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load    = accept;
        cmd_o.clr_max = accept && (opcode_i == ecpc_pkg::OP_CLEAR_MAX);
        cmd_o.scan    = accept && (opcode_i == ecpc_pkg::OP_SCAN);
        cmd_o.wr_pal  = accept && (opcode_i == ecpc_pkg::OP_WRITE_PAL);
        if (accept && (opcode_i == ecpc_pkg::OP_MAP)) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (!stat_i.pal_path) begin
          state_d = S_DONE;
        end else if (stat_i.relative) begin
          state_d = S_MUL;
        end else begin
          state_d = S_MOD_GO;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = S_MOD_GO;
        end
      end
      S_MOD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_mod   = 1'b1;
        state_d         = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        cmd_o.div_mod = 1'b1;
        if (!stat_i.div_busy) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register loaded while a stalled word waits");

  // Words other than a map finish in the cycle they are taken.
  a_single_cycle_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i != ecpc_pkg::OP_MAP)) |=> (state_q == S_IDLE))
    else $error("non-map word left the controller busy");

  // A map always starts sequencing in the following cycle.
  a_map_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == ecpc_pkg::OP_MAP)) |=> (state_q == S_CLASS))
    else $error("map word did not start sequencing");

  // The palette is only read once the modulo pass has finished.
  a_read_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ram_rd |-> !stat_i.div_busy)
    else $error("palette read while the divider is busy");

endmodule

`default_nettype wire

/* rtl/core/escape_count_palette_colorizer_top.sv */
// Top level of the escape count palette colorizer.
// Clear, scan and palette write words complete in the cycle they are accepted.
// A map to the set color or to white passes S_CLASS and S_DONE into the output register; a
// palette map also takes the modulo pass and the palette read, and in relative mode first the
// multiply and the scaling divide; the divider produces one quotient bit per cycle.
// One map at a time; the next word is taken once the result sits in the output register.
// Reset clears the controller and frame maximum and restores the configuration; the palette is kept.
`default_nettype none

module escape_count_palette_colorizer_top #(
  parameter int unsigned PALETTE_DEPTH = 512,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write port.
  input  wire logic                        cfg_we_i,
  input  wire logic [ecpc_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [ecpc_pkg::CFG_DW-1:0] cfg_data_i,
  // Input word channel.
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic                        in_set_i,
  input  wire logic                        has_count_i,
  input  wire logic [COUNT_BITS-1:0]       escape_count_i,
  input  wire logic [8:0]                  entry_index_i,
  input  wire logic [31:0]                 entry_color_i,
  // Result word channel.
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [31:0]                      pixel_rgba_o,
  output logic [1:0]                       color_source_o
);

  // The controller sequences each map through classification and, for palette maps,
  // the optional scaling multiply and divide, the modulo pass and the palette read.
  // The datapath holds all storage and arithmetic and reports only what sequencing needs.
  ecpc_pkg::ctrl_cmd_t  cmd;
  ecpc_pkg::ctrl_stat_t stat;

  ecpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The output register parts the two channels, so a result may wait for its
  // receiver while clear, scan and palette write words keep flowing in.
  ecpc_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_set_i       (in_set_i),
    .has_count_i    (has_count_i),
    .escape_count_i (escape_count_i),
    .entry_index_i  (entry_index_i),
    .entry_color_i  (entry_color_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pixel_rgba_o   (pixel_rgba_o),
    .color_source_o (color_source_o)
  );

endmodule

`default_nettype wire
